// ----- src/kmst_pkg.sv -----
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the spanning tree engine: payload words,
// controller states and the command and status groups between its parts.
// ----------------------------------------------------------------------------
package kmst_pkg;

   localparam logic [6:0] VERTEX_COUNT_RESET = 7'd64;
   localparam logic [0:0] REG_VERTEX_COUNT   = 1'b0;

   typedef struct packed {
      logic [5:0]         edge_src;
      logic [5:0]         edge_dest;
      logic signed [15:0] edge_weight;
      logic               last_edge;
   } req_type;

   typedef struct packed {
      logic [5:0]         tree_src;
      logic [5:0]         tree_dest;
      logic signed [15:0] tree_weight;
      logic               edge_present;
      logic               overflowed;
      logic               last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_FA_CHECK,
      ST_FA_WAIT,
      ST_FB_CHECK,
      ST_FB_WAIT,
      ST_JOIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic init;
      logic scan_issue;
      logic next_pass;
      logic walk_load;
      logic root_a_take;
      logic unite;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic best_found;
      logic in_range;
      logic cur_valid;
      logic roots_differ;
      logic limit_hit;
      logic limit_zero;
   } status_type;

endpackage

// ----- src/kmst_datapath.sv -----
// ----------------------------------------------------------------------------
// kmst_datapath
// Edge store, selection scan for the next edge in weight order, union-find
// parent memory with root walk, result register and vertex count register.
// ----------------------------------------------------------------------------
module kmst_datapath #(
   parameter int VERTEX_LIMIT = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  kmst_pkg::cmd_type   cmd,
   input  kmst_pkg::req_type   req_data,
   output kmst_pkg::status_type status,
   output logic                rsp_valid,
   output kmst_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata
);

   localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int VW    = $clog2(VERTEX_LIMIT);
   localparam int NW    = (VW + 1 > 7) ? VW + 1 : 7;
   localparam int EW    = 28;

   // vertex count register
   logic [6:0] vcount_ff, vcount_in;
   logic       csr_wr;
   logic       csr_hit;
   assign csr_hit = (paddr[2] == kmst_pkg::REG_VERTEX_COUNT) && (paddr[1:0] == 2'b00);
   assign csr_wr = psel && penable && pwrite && csr_hit;
   assign vcount_in = csr_wr ? pwdata[6:0] : vcount_ff;
   always_ff @(posedge clock) begin
      if (reset) vcount_ff <= kmst_pkg::VERTEX_COUNT_RESET;
      else       vcount_ff <= vcount_in;
   end
   assign prdata = csr_hit ? {25'd0, vcount_ff} : 32'd0;

   logic [NW-1:0] nv;
   always_comb begin
      if (NW'(vcount_ff) > NW'(VERTEX_LIMIT)) nv = NW'(VERTEX_LIMIT);
      else                                   nv = NW'(vcount_ff);
   end

   // edge store
   logic [EW-1:0]    edge_mem [MAX_EDGES];
   logic [EW-1:0]    rd_q_ff;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             ovf_ff, ovf_in;
   logic             store_wr;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;

   assign store_wr = cmd.load && (total_ff < CNT_W'(MAX_EDGES));

   always_ff @(posedge clock) begin
      if (store_wr)
         edge_mem[total_ff[IDX_W-1:0]] <= {req_data.edge_src, req_data.edge_dest,
                                            req_data.edge_weight};
      rd_q_ff <= edge_mem[scan_idx_ff];
   end

   always_comb begin
      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (store_wr)       total_in = total_ff + CNT_W'(1);
      else if (cmd.load)  ovf_in   = 1'b1;
      if (cmd.finish) begin
         total_in = '0;
         ovf_in   = 1'b0;
      end
   end

   // selection scan
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             have_prev_ff, have_prev_in;
   logic signed [15:0] prev_w_ff, prev_w_in;
   logic [IDX_W-1:0] prev_idx_ff, prev_idx_in;
   logic             best_found_ff, best_found_in;
   logic [5:0]       best_src_ff, best_src_in, best_dest_ff, best_dest_in;
   logic signed [15:0] best_w_ff, best_w_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [5:0]       c_src, c_dest;
   logic signed [15:0] c_w;
   logic             after_prev, beats_best;

   assign c_src  = rd_q_ff[27:22];
   assign c_dest = rd_q_ff[21:16];
   assign c_w    = rd_q_ff[15:0];
   assign after_prev = !have_prev_ff || (c_w > prev_w_ff)
                       || ((c_w == prev_w_ff) && (rd_idx_ff > prev_idx_ff));
   assign beats_best = !best_found_ff || (c_w < best_w_ff);

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      have_prev_in  = have_prev_ff;
      prev_w_in     = prev_w_ff;
      prev_idx_in   = prev_idx_ff;
      best_found_in = best_found_ff;
      best_src_in   = best_src_ff;
      best_dest_in  = best_dest_ff;
      best_w_in     = best_w_ff;
      best_idx_in   = best_idx_ff;
      if (cmd.scan_issue) scan_idx_in = scan_idx_ff + IDX_W'(1);
      if (rd_vld_ff && after_prev && beats_best) begin
         best_found_in = 1'b1;
         best_src_in   = c_src;
         best_dest_in  = c_dest;
         best_w_in     = c_w;
         best_idx_in   = rd_idx_ff;
      end
      if (cmd.init) begin
         scan_idx_in   = '0;
         have_prev_in  = 1'b0;
         best_found_in = 1'b0;
      end
      if (cmd.next_pass) begin
         scan_idx_in   = '0;
         have_prev_in  = 1'b1;
         prev_w_in     = best_w_ff;
         prev_idx_in   = best_idx_ff;
         best_found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         rd_vld_ff     <= 1'b0;
         scan_idx_ff   <= '0;
         have_prev_ff  <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         rd_vld_ff     <= cmd.scan_issue;
         scan_idx_ff   <= scan_idx_in;
         have_prev_ff  <= have_prev_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= scan_idx_ff;
      prev_w_ff    <= prev_w_in;
      prev_idx_ff  <= prev_idx_in;
      best_src_ff  <= best_src_in;
      best_dest_ff <= best_dest_in;
      best_w_ff    <= best_w_in;
      best_idx_ff  <= best_idx_in;
   end

   // union-find parent memory, valid bit set means entry holds a parent
   logic [VW-1:0]           parent_mem [VERTEX_LIMIT];
   logic [VW-1:0]           par_q_ff;
   logic [VERTEX_LIMIT-1:0] pvalid_ff, pvalid_in;
   logic [VW-1:0]           cur_ff, cur_in, root_a_ff, root_a_in;
   logic [NW-1:0]           acc_ff, acc_in;
   logic                    do_join;

   assign do_join = cmd.unite && (root_a_ff != cur_ff);

   always_ff @(posedge clock) begin
      if (do_join) parent_mem[root_a_ff] <= cur_ff;
      par_q_ff <= parent_mem[cur_ff];
   end

   always_comb begin
      cur_in    = cur_ff;
      root_a_in = root_a_ff;
      pvalid_in = pvalid_ff;
      acc_in    = acc_ff;
      if (cmd.next_pass) cur_in = VW'(best_src_ff);
      if (cmd.walk_load) cur_in = par_q_ff;
      if (cmd.root_a_take) begin
         root_a_in = cur_ff;
         cur_in    = VW'(best_dest_ff);
      end
      if (do_join) begin
         pvalid_in[root_a_ff] = 1'b1;
         acc_in               = acc_ff + NW'(1);
      end
      if (cmd.init) begin
         pvalid_in = '0;
         acc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= '0;
         acc_ff    <= '0;
      end else begin
         pvalid_ff <= pvalid_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      root_a_ff <= root_a_in;
   end

   // pending tree edge, held back so the final one can carry the last mark
   logic            pend_ff, pend_in;
   logic [5:0]      pend_src_ff, pend_dest_ff;
   logic signed [15:0] pend_w_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   kmst_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (do_join) begin
         pend_in = 1'b1;
         if (pend_ff) begin
            rsp_valid_in        = 1'b1;
            rsp_in.tree_src     = pend_src_ff;
            rsp_in.tree_dest    = pend_dest_ff;
            rsp_in.tree_weight  = pend_w_ff;
            rsp_in.edge_present = 1'b1;
            rsp_in.overflowed   = ovf_ff;
            rsp_in.last_result  = 1'b0;
         end
      end
      if (cmd.finish) begin
         pend_in             = 1'b0;
         rsp_valid_in        = 1'b1;
         rsp_in.tree_src     = pend_ff ? pend_src_ff : 6'd0;
         rsp_in.tree_dest    = pend_ff ? pend_dest_ff : 6'd0;
         rsp_in.tree_weight  = pend_ff ? pend_w_ff : 16'sd0;
         rsp_in.edge_present = pend_ff;
         rsp_in.overflowed   = ovf_ff;
         rsp_in.last_result  = 1'b1;
      end
      if (cmd.init) pend_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (do_join) begin
         pend_src_ff  <= best_src_ff;
         pend_dest_ff <= best_dest_ff;
         pend_w_ff    <= best_w_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.scan_last    = (CNT_W'(scan_idx_ff) + CNT_W'(1)) >= total_ff;
   assign status.best_found   = best_found_ff;
   assign status.in_range     = (NW'(best_src_ff) < nv) && (NW'(best_dest_ff) < nv);
   assign status.cur_valid    = pvalid_ff[cur_ff];
   assign status.roots_differ = root_a_ff != cur_ff;
   assign status.limit_hit    = ((NW+1)'(acc_ff) + (NW+1)'(2)) == (NW+1)'(nv);
   assign status.limit_zero   = nv <= NW'(1);

endmodule

// ----- src/kmst_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: edge loading, selection passes, root walks and result release.
// ----------------------------------------------------------------------------
module kmst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 last_edge,
   input  kmst_pkg::status_type status,
   output kmst_pkg::cmd_type    cmd,
   output logic                 busy
);

   kmst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= kmst_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kmst_pkg::ST_IDLE:
            if (start && last_edge) state_in = kmst_pkg::ST_INIT;
         kmst_pkg::ST_INIT:
            state_in = status.limit_zero ? kmst_pkg::ST_DONE : kmst_pkg::ST_SCAN;
         kmst_pkg::ST_SCAN:
            if (status.scan_last) state_in = kmst_pkg::ST_DRAIN;
         kmst_pkg::ST_DRAIN:
            state_in = kmst_pkg::ST_EVAL;
         kmst_pkg::ST_EVAL: begin
            if (!status.best_found)    state_in = kmst_pkg::ST_DONE;
            else if (!status.in_range) state_in = kmst_pkg::ST_SCAN;
            else                       state_in = kmst_pkg::ST_FA_CHECK;
         end
         kmst_pkg::ST_FA_CHECK:
            state_in = status.cur_valid ? kmst_pkg::ST_FA_WAIT : kmst_pkg::ST_FB_CHECK;
         kmst_pkg::ST_FA_WAIT:
            state_in = kmst_pkg::ST_FA_CHECK;
         kmst_pkg::ST_FB_CHECK:
            state_in = status.cur_valid ? kmst_pkg::ST_FB_WAIT : kmst_pkg::ST_JOIN;
         kmst_pkg::ST_FB_WAIT:
            state_in = kmst_pkg::ST_FB_CHECK;
         kmst_pkg::ST_JOIN:
            state_in = (status.roots_differ && status.limit_hit) ? kmst_pkg::ST_DONE
                                                                : kmst_pkg::ST_SCAN;
         kmst_pkg::ST_DONE:
            state_in = kmst_pkg::ST_IDLE;
         default:
            state_in = kmst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         kmst_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         kmst_pkg::ST_INIT:     cmd.init        = 1'b1;
         kmst_pkg::ST_SCAN:     cmd.scan_issue  = 1'b1;
         kmst_pkg::ST_DRAIN:    ;
         kmst_pkg::ST_EVAL:     cmd.next_pass   = 1'b1;
         kmst_pkg::ST_FA_CHECK: cmd.root_a_take = !status.cur_valid;
         kmst_pkg::ST_FA_WAIT:  cmd.walk_load   = 1'b1;
         kmst_pkg::ST_FB_CHECK: ;
         kmst_pkg::ST_FB_WAIT:  cmd.walk_load   = 1'b1;
         kmst_pkg::ST_JOIN:     cmd.unite       = 1'b1;
         kmst_pkg::ST_DONE:     cmd.finish      = 1'b1;
         default:               busy            = 1'b1;
      endcase
   end

endmodule

// ----- src/kruskal_minimum_spanning_tree.sv -----
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree
// Minimum spanning tree engine: edges are loaded one word per cycle while
// busy is low; the word marked last starts the tree computation. The
// computation then runs with busy high: each tree edge is found by a
// selection pass over the E stored edges through the single edge store
// read port (at most E + 1 passes, the last one finding no edge), followed
// by two root walks in the parent memory. Results leave as single-cycle
// strobes on rsp_valid and cannot be stalled; the word carrying last_result
// comes in the first cycle with busy low. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree #(
   parameter int VERTEX_LIMIT = 64,
   parameter int MAX_EDGES    = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  kmst_pkg::req_type req_data,
   output logic              rsp_valid,
   output kmst_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   kmst_pkg::cmd_type    cmd;
   kmst_pkg::status_type status;

   assign pready = 1'b1;

   kmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_edge (req_data.last_edge),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   kmst_datapath #(
      .VERTEX_LIMIT (VERTEX_LIMIT),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata)
   );

endmodule

// ----- src/kmst_checker.sv -----
// ----------------------------------------------------------------------------
// kmst_checker
// Port-level checks of the spanning tree engine, bound to its top level.
// ----------------------------------------------------------------------------
module kmst_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input kmst_pkg::req_type req_data,
   input logic              rsp_valid,
   input kmst_pkg::rsp_type rsp_data
);

   // a plain edge word never starts a computation
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_data.last_edge |=> !busy)
      else $error("busy after a plain edge word");

   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last_edge |=> busy)
      else $error("last edge word did not start the tree");

   a_mid_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> busy)
      else $error("intermediate result outside a computation");

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |-> !busy)
      else $error("final result while still busy");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.edge_present |-> rsp_data.last_result
                                              && rsp_data.tree_src == 6'd0)
      else $error("empty result malformed");

endmodule

bind kruskal_minimum_spanning_tree kmst_checker u_kmst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
